// File: hw/rtl/ticmfp_pkg.sv
// types and constants shared by the meter teleinformation frame parser
// no dependencies
package ticmfp_pkg;

    localparam int MAX_VALUE_CHARS = 9;

    localparam logic [6:0] CH_STX = 7'h02;
    localparam logic [6:0] CH_ETX = 7'h03;
    localparam logic [6:0] CH_LF  = 7'h0A;
    localparam logic [6:0] CH_CR  = 7'h0D;
    localparam logic [6:0] CH_SP  = 7'h20;
    localparam logic [6:0] CH_0   = 7'h30;
    localparam logic [6:0] CH_9   = 7'h39;
    localparam logic [6:0] CH_P   = 7'h50;
    localparam logic [6:0] CH_C   = 7'h43;

    localparam logic [3:0] IDX_STOP = 4'd15;

    localparam logic [29:0] INDEX_MAX   = 30'd999999999;
    localparam logic [29:0] CURRENT_MAX = 30'd999;
    localparam logic [29:0] POWER_MAX   = 30'd99999;

    localparam logic [1:0] PERIOD_UNKNOWN = 2'd0;
    localparam logic [1:0] PERIOD_PEAK    = 2'd1;
    localparam logic [1:0] PERIOD_OFFPEAK = 2'd2;

    // found mask bit positions
    localparam int FB_HCHC  = 0;
    localparam int FB_HCHP  = 1;
    localparam int FB_PTEC  = 2;
    localparam int FB_IINST = 3;
    localparam int FB_PAPP  = 4;
    localparam int NUM_LABELS = 5;

    // labels packed 7 bits per character, first character most significant
    localparam logic [34:0] LBL_HCHC  = 35'({7'h48, 7'h43, 7'h48, 7'h43});
    localparam logic [34:0] LBL_HCHP  = 35'({7'h48, 7'h43, 7'h48, 7'h50});
    localparam logic [34:0] LBL_PTEC  = 35'({7'h50, 7'h54, 7'h45, 7'h43});
    localparam logic [34:0] LBL_IINST = {7'h49, 7'h49, 7'h4E, 7'h53, 7'h54};
    localparam logic [34:0] LBL_PAPP  = 35'({7'h50, 7'h41, 7'h50, 7'h50});

    typedef enum logic [3:0] {
        PH_OUT   = 4'b0001,
        PH_LABEL = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_SKIP  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        FSEL_NONE  = 3'd0,
        FSEL_HCHC  = 3'd1,
        FSEL_HCHP  = 3'd2,
        FSEL_PTEC  = 3'd3,
        FSEL_IINST = 3'd4,
        FSEL_PAPP  = 3'd5
    } field_sel_t;

    typedef struct packed {
        logic [29:0] offpeak_index;
        logic [29:0] peak_index;
        logic [9:0]  current_amps;
        logic [16:0] apparent_power;
        logic [1:0]  tariff_period;
        logic [4:0]  found_mask;
    } result_t;

    function automatic logic [29:0] field_max(input field_sel_t sel);
        logic [29:0] mx;
        case (sel)
            FSEL_HCHC:  mx = INDEX_MAX;
            FSEL_HCHP:  mx = INDEX_MAX;
            FSEL_IINST: mx = CURRENT_MAX;
            FSEL_PAPP:  mx = POWER_MAX;
            default:    mx = '0;
        endcase
        return mx;
    endfunction

endpackage

// File: hw/rtl/tic_meter_frame_parser.sv
// Teleinformation frame parser for an electricity meter in historic mode. One 7-bit
// character is taken per transaction, one every cycle at full rate. A character
// passes an input register, then the parser updates its state from it. An ETX
// inside a frame, once the parser steps on it, loads the result register and
// raises m_valid. Labels HCHC, HCHP, PTEC, IINST and PAPP are decoded, numeric
// values saturate at their field maximum, and labels missing from a frame keep
// their earlier values. The result register decouples the two sides; input stalls
// only when both registers are full and m_ready is low.
// depends on ticmfp_pkg and ticmfp_parse_core
module tic_meter_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [6:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [29:0] m_offpeak_index,
    output logic [29:0] m_peak_index,
    output logic [9:0]  m_current_amps,
    output logic [16:0] m_apparent_power,
    output logic [1:0]  m_tariff_period,
    output logic [4:0]  m_found_mask
);
    import ticmfp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [6:0] in_byte_reg;
    logic       m_valid_reg, m_valid_next;
    result_t    res_reg;
    result_t    res;
    logic       out_ready;
    logic       step;
    logic       emit;

    assign out_ready = !m_valid_reg || m_ready;
    assign step      = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    ticmfp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (emit) begin
            res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_offpeak_index  = res_reg.offpeak_index;
    assign m_peak_index     = res_reg.peak_index;
    assign m_current_amps   = res_reg.current_amps;
    assign m_apparent_power = res_reg.apparent_power;
    assign m_tariff_period  = res_reg.tariff_period;
    assign m_found_mask     = res_reg.found_mask;

`ifndef SYNTH
    a_period_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tariff_period == PERIOD_UNKNOWN || m_tariff_period == PERIOD_PEAK
                     || m_tariff_period == PERIOD_OFFPEAK))
        else $error("tariff period code out of range");

    a_index_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_offpeak_index <= INDEX_MAX && m_peak_index <= INDEX_MAX))
        else $error("energy index above saturation limit");

    a_small_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (30'(m_current_amps) <= CURRENT_MAX
                     && 30'(m_apparent_power) <= POWER_MAX))
        else $error("current or power above saturation limit");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_ready) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled character lost from input register");
`endif

endmodule

// File: hw/rtl/ticmfp_parse_core.sv
// per-character parser state, label match, value accumulation and stores
// depends on ticmfp_pkg
module ticmfp_parse_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [6:0]          rx_byte,
    output logic                emit,
    output ticmfp_pkg::result_t result
);
    import ticmfp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [34:0] label_reg, label_next;
    logic [2:0]  len_reg, len_next;
    field_sel_t  sel_reg, sel_next;
    logic [29:0] acc_reg, acc_next;
    logic [3:0]  idx_reg, idx_next;
    logic [4:0]  found_reg, found_next;
    logic [29:0] offpeak_reg, offpeak_next;
    logic [29:0] peak_reg, peak_next;
    logic [9:0]  current_reg, current_next;
    logic [16:0] power_reg, power_next;
    logic [1:0]  period_reg, period_next;

    logic [NUM_LABELS-1:0] hit;
    field_sel_t            sel_match;
    logic                  do_commit;
    logic                  incr;
    logic [33:0]           acc_x10;
    logic [29:0]           mx;

    // label match against all known labels in parallel
    always_comb begin
        hit[FB_HCHC]  = (len_reg == 3'd4) && (label_reg == LBL_HCHC);
        hit[FB_HCHP]  = (len_reg == 3'd4) && (label_reg == LBL_HCHP);
        hit[FB_PTEC]  = (len_reg == 3'd4) && (label_reg == LBL_PTEC);
        hit[FB_IINST] = (len_reg == 3'd5) && (label_reg == LBL_IINST);
        hit[FB_PAPP]  = (len_reg == 3'd4) && (label_reg == LBL_PAPP);
        sel_match = FSEL_NONE;
        for (int k = 0; k < NUM_LABELS; k++) begin
            if (hit[k]) begin
                sel_match = field_sel_t'(3'(k + 1));
            end
        end
    end

    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + 34'(7'(rx_byte - CH_0));
    assign mx = field_max(sel_reg);

    always_comb begin
        phase_next   = phase_reg;
        label_next   = label_reg;
        len_next     = len_reg;
        sel_next     = sel_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        offpeak_next = offpeak_reg;
        peak_next    = peak_reg;
        current_next = current_reg;
        power_next   = power_reg;
        period_next  = period_reg;
        do_commit    = 1'b0;
        incr         = 1'b0;
        emit         = 1'b0;

        if (step) begin
            if (rx_byte == CH_STX) begin
                found_next = '0;
                phase_next = PH_LABEL;
                label_next = '0;
                len_next   = '0;
                sel_next   = FSEL_NONE;
                acc_next   = '0;
                idx_next   = '0;
            end else if (phase_reg != PH_OUT) begin
                if (rx_byte == CH_ETX) begin
                    do_commit  = (phase_reg == PH_VALUE);
                    emit       = 1'b1;
                    phase_next = PH_OUT;
                    sel_next   = FSEL_NONE;
                end else if (rx_byte == CH_LF) begin
                    do_commit  = (phase_reg == PH_VALUE);
                    phase_next = PH_LABEL;
                    label_next = '0;
                    len_next   = '0;
                    sel_next   = FSEL_NONE;
                    acc_next   = '0;
                    idx_next   = '0;
                end else if (rx_byte == CH_CR) begin
                    do_commit  = (phase_reg == PH_VALUE);
                    phase_next = PH_SKIP;
                    sel_next   = FSEL_NONE;
                end else begin
                    case (phase_reg)
                        PH_LABEL: begin
                            if (rx_byte == CH_SP) begin
                                sel_next   = FSEL_NONE;
                                phase_next = PH_SKIP;
                                if (sel_match != FSEL_NONE && !(|(hit & found_reg))) begin
                                    sel_next   = sel_match;
                                    phase_next = PH_VALUE;
                                    acc_next   = '0;
                                    idx_next   = '0;
                                end
                            end else if (len_reg < 3'd5) begin
                                label_next = {label_reg[27:0], rx_byte};
                                len_next   = len_reg + 3'd1;
                            end else begin
                                len_next = 3'd6;
                            end
                        end
                        PH_VALUE: begin
                            if (rx_byte == CH_SP) begin
                                do_commit  = 1'b1;
                                phase_next = PH_SKIP;
                                sel_next   = FSEL_NONE;
                            end else if (sel_reg == FSEL_PTEC) begin
                                incr = 1'b1;
                                if (idx_reg == 4'd1) begin
                                    if (rx_byte == CH_P) begin
                                        acc_next = 30'(PERIOD_PEAK);
                                    end else if (rx_byte == CH_C) begin
                                        acc_next = 30'(PERIOD_OFFPEAK);
                                    end else begin
                                        acc_next = 30'(PERIOD_UNKNOWN);
                                    end
                                end
                            end else if (idx_reg < 4'(MAX_VALUE_CHARS)) begin
                                if (rx_byte inside {[CH_0:CH_9]}) begin
                                    incr     = 1'b1;
                                    acc_next = (acc_x10 > {4'b0, mx}) ? mx : acc_x10[29:0];
                                end else begin
                                    idx_next = IDX_STOP;
                                end
                            end else begin
                                incr = 1'b1;
                            end
                            if (incr && idx_reg != IDX_STOP) begin
                                idx_next = idx_reg + 4'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        if (do_commit) begin
            case (sel_reg)
                FSEL_HCHC: begin
                    offpeak_next        = acc_reg;
                    found_next[FB_HCHC] = 1'b1;
                end
                FSEL_HCHP: begin
                    peak_next           = acc_reg;
                    found_next[FB_HCHP] = 1'b1;
                end
                FSEL_PTEC: begin
                    period_next         = acc_reg[1:0];
                    found_next[FB_PTEC] = 1'b1;
                end
                FSEL_IINST: begin
                    current_next         = acc_reg[9:0];
                    found_next[FB_IINST] = 1'b1;
                end
                FSEL_PAPP: begin
                    power_next          = acc_reg[16:0];
                    found_next[FB_PAPP] = 1'b1;
                end
                default: begin
                end
            endcase
        end

        result.offpeak_index  = offpeak_next;
        result.peak_index     = peak_next;
        result.current_amps   = current_next;
        result.apparent_power = power_next;
        result.tariff_period  = period_next;
        result.found_mask     = found_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_OUT;
            label_reg   <= '0;
            len_reg     <= '0;
            sel_reg     <= FSEL_NONE;
            acc_reg     <= '0;
            idx_reg     <= '0;
            found_reg   <= '0;
            offpeak_reg <= '0;
            peak_reg    <= '0;
            current_reg <= '0;
            power_reg   <= '0;
            period_reg  <= PERIOD_UNKNOWN;
        end else begin
            phase_reg   <= phase_next;
            label_reg   <= label_next;
            len_reg     <= len_next;
            sel_reg     <= sel_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            found_reg   <= found_next;
            offpeak_reg <= offpeak_next;
            peak_reg    <= peak_next;
            current_reg <= current_next;
            power_reg   <= power_next;
            period_reg  <= period_next;
        end
    end

endmodule

// File: tb/sv/tic_frame_checker.sv
`timescale 1ns / 1ps
// watches both channels of the teleinformation frame parser, predicts each frame result
// from the received characters and compares it field by field; depends on ticmfp_pkg
module tic_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [6:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [29:0] m_offpeak_index,
    input  logic [29:0] m_peak_index,
    input  logic [9:0]  m_current_amps,
    input  logic [16:0] m_apparent_power,
    input  logic [1:0]  m_tariff_period,
    input  logic [4:0]  m_found_mask,
    output int          mismatches,
    output int          expected_left
);
    import ticmfp_pkg::*;

    phase_t      line_phase;
    logic [34:0] label_buf;
    logic [2:0]  label_len;
    field_sel_t  target_field;
    logic [29:0] digit_acc;
    logic [3:0]  digit_pos;
    logic [4:0]  seen_mask;
    logic [29:0] hchc_wh;
    logic [29:0] hchp_wh;
    logic [9:0]  iinst_a;
    logic [16:0] papp_va;
    logic [1:0]  ptec_period;

    result_t expected_frames[$];
    int      result_count = 0;

    task automatic report_mismatch(input string what, input logic [29:0] got,
                                   input logic [29:0] want);
        $display("frame result %0d: %s got %0d expected %0d", result_count, what, got, want);
        mismatches++;
    endtask

    task automatic clear_state();
        line_phase   = PH_OUT;
        label_buf    = '0;
        label_len    = '0;
        target_field = FSEL_NONE;
        digit_acc    = '0;
        digit_pos    = '0;
        seen_mask    = '0;
        hchc_wh      = '0;
        hchp_wh      = '0;
        iinst_a      = '0;
        papp_va      = '0;
        ptec_period  = PERIOD_UNKNOWN;
    endtask

    task automatic open_line();
        line_phase   = PH_LABEL;
        label_buf    = '0;
        label_len    = '0;
        target_field = FSEL_NONE;
        digit_acc    = '0;
        digit_pos    = '0;
    endtask

    task automatic store_value();
        case (target_field)
            FSEL_HCHC: begin
                hchc_wh = digit_acc;
                seen_mask[FB_HCHC] = 1'b1;
            end
            FSEL_HCHP: begin
                hchp_wh = digit_acc;
                seen_mask[FB_HCHP] = 1'b1;
            end
            FSEL_PTEC: begin
                ptec_period = digit_acc[1:0];
                seen_mask[FB_PTEC] = 1'b1;
            end
            FSEL_IINST: begin
                iinst_a = digit_acc[9:0];
                seen_mask[FB_IINST] = 1'b1;
            end
            FSEL_PAPP: begin
                papp_va = digit_acc[16:0];
                seen_mask[FB_PAPP] = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic close_label();
        field_sel_t hit;
        hit = FSEL_NONE;
        target_field = FSEL_NONE;
        line_phase = PH_SKIP;
        if (label_len == 3'd4) begin
            if (label_buf == LBL_HCHC) hit = FSEL_HCHC;
            else if (label_buf == LBL_HCHP) hit = FSEL_HCHP;
            else if (label_buf == LBL_PTEC) hit = FSEL_PTEC;
            else if (label_buf == LBL_PAPP) hit = FSEL_PAPP;
        end else if (label_len == 3'd5 && label_buf == LBL_IINST) begin
            hit = FSEL_IINST;
        end
        // a label already stored in this frame is skipped
        if (hit != FSEL_NONE && !seen_mask[int'(hit) - 1]) begin
            target_field = hit;
            line_phase = PH_VALUE;
            digit_acc = '0;
            digit_pos = '0;
        end
    endtask

    task automatic take_value_char(input logic [6:0] c);
        logic [3:0]  pos;
        logic [63:0] wide;
        logic [29:0] cap;
        pos = digit_pos;
        if (target_field == FSEL_PTEC) begin
            if (pos == 4'd1) begin
                if (c == CH_P) digit_acc = 30'(PERIOD_PEAK);
                else if (c == CH_C) digit_acc = 30'(PERIOD_OFFPEAK);
                else digit_acc = 30'(PERIOD_UNKNOWN);
            end
        end else if (target_field != FSEL_NONE && pos < MAX_VALUE_CHARS) begin
            if (c >= CH_0 && c <= CH_9) begin
                case (target_field)
                    FSEL_IINST: cap = CURRENT_MAX;
                    FSEL_PAPP:  cap = POWER_MAX;
                    default:    cap = INDEX_MAX;
                endcase
                wide = 64'(digit_acc) * 64'd10 + 64'(c - CH_0);
                digit_acc = (wide > 64'(cap)) ? cap : wide[29:0];
            end else begin
                digit_pos = IDX_STOP;
                return;
            end
        end
        if (digit_pos < IDX_STOP) digit_pos = pos + 4'd1;
    endtask

    task automatic parse_char(input logic [6:0] c);
        result_t r;
        if (c == CH_STX) begin
            seen_mask = '0;
            open_line();
        end else if (line_phase != PH_OUT) begin
            if (c == CH_ETX) begin
                if (line_phase == PH_VALUE) store_value();
                r.offpeak_index  = hchc_wh;
                r.peak_index     = hchp_wh;
                r.current_amps   = iinst_a;
                r.apparent_power = papp_va;
                r.tariff_period  = ptec_period;
                r.found_mask     = seen_mask;
                expected_frames.push_back(r);
                line_phase = PH_OUT;
                target_field = FSEL_NONE;
            end else if (c == CH_LF) begin
                if (line_phase == PH_VALUE) store_value();
                open_line();
            end else if (c == CH_CR) begin
                if (line_phase == PH_VALUE) store_value();
                line_phase = PH_SKIP;
                target_field = FSEL_NONE;
            end else if (line_phase == PH_LABEL) begin
                if (c == CH_SP) begin
                    close_label();
                end else if (label_len < 3'd5) begin
                    label_buf = {label_buf[27:0], c};
                    label_len = label_len + 3'd1;
                end else begin
                    label_len = 3'd6;
                end
            end else if (line_phase == PH_VALUE) begin
                if (c == CH_SP) begin
                    store_value();
                    line_phase = PH_SKIP;
                    target_field = FSEL_NONE;
                end else begin
                    take_value_char(c);
                end
            end
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_state();
            expected_frames.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.offpeak_index  = m_offpeak_index;
                got.peak_index     = m_peak_index;
                got.current_amps   = m_current_amps;
                got.apparent_power = m_apparent_power;
                got.tariff_period  = m_tariff_period;
                got.found_mask     = m_found_mask;
                if (expected_frames.size() == 0) begin
                    report_mismatch("transaction with no frame pending, found_mask",
                                    30'(got.found_mask), '0);
                end else begin
                    want = expected_frames.pop_front();
                    if (got.offpeak_index !== want.offpeak_index)
                        report_mismatch("offpeak_index", got.offpeak_index, want.offpeak_index);
                    if (got.peak_index !== want.peak_index)
                        report_mismatch("peak_index", got.peak_index, want.peak_index);
                    if (got.current_amps !== want.current_amps)
                        report_mismatch("current_amps", 30'(got.current_amps),
                                        30'(want.current_amps));
                    if (got.apparent_power !== want.apparent_power)
                        report_mismatch("apparent_power", 30'(got.apparent_power),
                                        30'(want.apparent_power));
                    if (got.tariff_period !== want.tariff_period)
                        report_mismatch("tariff_period", 30'(got.tariff_period),
                                        30'(want.tariff_period));
                    if (got.found_mask !== want.found_mask)
                        report_mismatch("found_mask", 30'(got.found_mask),
                                        30'(want.found_mask));
                end
                result_count++;
            end
            if (s_valid && s_ready) parse_char(s_rx_byte);
        end
        expected_left <= expected_frames.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for the teleinformation frame parser: directed and random frames
// with bursty input and stalling output; depends on ticmfp_pkg and tic_frame_checker
module testbench;
    import ticmfp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int FRAMES_MIN  = 24;
    localparam int CHARS_MIN   = 600;
    localparam int HOLD_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [6:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [29:0] m_offpeak_index;
    logic [29:0] m_peak_index;
    logic [9:0]  m_current_amps;
    logic [16:0] m_apparent_power;
    logic [1:0]  m_tariff_period;
    logic [4:0]  m_found_mask;

    int mismatches;
    int expected_left;
    int burst_left = 0;
    int chars_sent = 0;
    int frames_sent = 0;
    int hold_seq = 0;

    tic_meter_frame_parser u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_offpeak_index  (m_offpeak_index),
        .m_peak_index     (m_peak_index),
        .m_current_amps   (m_current_amps),
        .m_apparent_power (m_apparent_power),
        .m_tariff_period  (m_tariff_period),
        .m_found_mask     (m_found_mask)
    );

    tic_frame_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_offpeak_index  (m_offpeak_index),
        .m_peak_index     (m_peak_index),
        .m_current_amps   (m_current_amps),
        .m_apparent_power (m_apparent_power),
        .m_tariff_period  (m_tariff_period),
        .m_found_mask     (m_found_mask),
        .mismatches       (mismatches),
        .expected_left    (expected_left)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        int seen_seq;
        int mode;
        int mode_left;
        hold_left = 0;
        seen_seq = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_seq != seen_seq) begin
                seen_seq = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_char(input logic [6:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_rx_byte <= c;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(7'(s[i]));
    endtask

    // any character that is not a frame, line or field delimiter
    function automatic logic [6:0] plain_char();
        logic [6:0] c;
        do c = 7'($urandom_range(0, 127));
        while (c == CH_STX || c == CH_ETX || c == CH_LF || c == CH_CR || c == CH_SP);
        return c;
    endfunction

    function automatic string label_text(input int k);
        case (k)
            FB_HCHC:  return "HCHC";
            FB_HCHP:  return "HCHP";
            FB_PTEC:  return "PTEC";
            FB_IINST: return "IINST";
            default:  return "PAPP";
        endcase
    endfunction

    task automatic send_reading();
        int len;
        int style;
        int bad_at;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 11);
        style = $urandom_range(0, 3);
        bad_at = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
            if (style == 2 && i == bad_at) send_char(plain_char());
            else if (style == 1) send_char(CH_9);
            else send_char(7'(CH_0 + $urandom_range(0, 9)));
        end
    endtask

    task automatic send_period();
        int len;
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
            if (i == 1) begin
                case ($urandom_range(0, 3))
                    0:       send_char(CH_P);
                    1:       send_char(CH_C);
                    2:       send_char(plain_char());
                    default: send_char(($urandom_range(0, 1) == 0) ? CH_P : CH_C);
                endcase
            end else begin
                send_char(plain_char());
            end
        end
    endtask

    task automatic send_value(input int k);
        if (k == FB_PTEC) send_period();
        else send_reading();
    endtask

    task automatic send_line();
        int kind;
        int k;
        int n;
        string s;
        kind = $urandom_range(0, 9);
        k = $urandom_range(0, NUM_LABELS - 1);
        send_char(CH_LF);
        if (kind < 7) begin
            send_text(label_text(k));
            send_char(CH_SP);
            send_value(k);
            case ($urandom_range(0, 9))
                0: send_char(CH_CR);
                1: ;
                2: begin
                    send_char(CH_SP);
                    send_char(plain_char());
                    send_char(plain_char());
                    send_char(CH_CR);
                end
                default: begin
                    send_char(CH_SP);
                    send_char(plain_char());
                    send_char(CH_CR);
                end
            endcase
        end else if (kind == 7) begin
            // near miss on a real label
            s = label_text(k);
            case ($urandom_range(0, 2))
                0:       s = s.substr(0, s.len() - 2);
                1:       s = {s, label_text($urandom_range(0, NUM_LABELS - 1))};
                default: s[$urandom_range(0, s.len() - 1)] = 8'(plain_char());
            endcase
            send_text(s);
            send_char(CH_SP);
            send_reading();
            send_char(CH_CR);
        end else if (kind == 8) begin
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) send_char(plain_char());
            if ($urandom_range(0, 1) == 0) send_char(CH_SP);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) send_char(plain_char());
            send_char(CH_CR);
        end else begin
            send_char(CH_SP);
            send_reading();
            send_char(CH_CR);
        end
    endtask

    task automatic send_frame();
        int lines;
        int n;
        logic [6:0] c;
        send_char(CH_STX);
        lines = $urandom_range(0, 5);
        for (int i = 0; i < lines; i++) begin
            if ($urandom_range(0, 29) == 0) send_char(CH_STX);
            send_line();
        end
        if ($urandom_range(0, 11) != 0) begin
            send_char(CH_ETX);
            frames_sent++;
        end
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                c = 7'($urandom_range(0, 127));
                send_char((c == CH_STX) ? CH_ETX : c);
            end
        end
    endtask

    initial begin : stimulus
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ignored outside a frame
        send_char(7'h7F);
        send_char(7'h00);
        send_char(CH_ETX);
        send_char(CH_STX);
        send_text("PAPP 99999");
        send_char(CH_CR);
        send_char(plain_char());
        send_char(CH_LF);
        // restart inside a frame keeps the stores
        send_char(CH_STX);
        send_text("PTEC HP");
        send_char(CH_ETX);

        // long output stall while empty frames keep arriving
        hold_seq++;
        for (int i = 0; i < 12; i++) begin
            send_char(CH_STX);
            send_char(CH_ETX);
            frames_sent++;
        end

        while (frames_sent < FRAMES_MIN || chars_sent < CHARS_MIN) send_frame();
        s_valid <= 1'b0;

        while (expected_left != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_left == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
